/* hdl/saw_pkg.sv */
`default_nettype none

package saw_pkg;

    // message length in bytes
    localparam int PAYLOAD_BYTES = 20;
    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    // field widths
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 20;
    localparam int SUM_W   = 23;
    localparam int CHK_W   = 13;
    localparam int TMR_W   = 16;

    localparam logic [TMR_W-1:0] TIMEOUT_RESET = TMR_W'(15);

    // input word opcodes
    localparam logic [OP_W-1:0] OP_MSG  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_ACK  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_TICK = OP_W'(2);

    // controller -> datapath
    typedef struct packed {
        logic in_take;   // input word accepted this cycle
        logic rd_start;  // read store entry 0
        logic rd_next;   // step to the next store entry
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit_req;  // the current input word starts a packet
        logic last;      // read pointer sits on the final byte
        logic awaiting;  // waiting for an acknowledgement
        logic timer_run; // retransmission timer nonzero
    } t_dp_status;

endpackage

`default_nettype wire

/* hdl/saw_if.sv */
`default_nettype none

// input words: message bytes, ack packet bytes, ticks
interface saw_in_if;
    logic                               valid;
    logic                               ready;
    logic [saw_pkg::OP_W-1:0]           op;
    logic signed [saw_pkg::BYTE_W-1:0]  data_byte;
    logic [saw_pkg::FIELD_W-1:0]        in_seq;
    logic [saw_pkg::FIELD_W-1:0]        in_ack;
    logic signed [saw_pkg::SUM_W-1:0]   in_check;

    modport source (output valid, op, data_byte, in_seq, in_ack, in_check, input ready);
    modport sink   (input valid, op, data_byte, in_seq, in_ack, in_check, output ready);
endinterface

// outgoing packet bytes
interface saw_out_if;
    logic                               valid;
    logic                               ready;
    logic                               out_seq;
    logic                               out_ack;
    logic signed [saw_pkg::CHK_W-1:0]   out_check;
    logic signed [saw_pkg::BYTE_W-1:0]  out_byte;
    logic                               out_last;

    modport source (output valid, out_seq, out_ack, out_check, out_byte, out_last,
                    input ready);
    modport sink   (input valid, out_seq, out_ack, out_check, out_byte, out_last,
                    output ready);
endinterface

// timeout register write
interface saw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [saw_pkg::TMR_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/saw_ctrl.sv */
`default_nettype none

module saw_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire saw_pkg::t_dp_status i_status,
    output saw_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SHOW
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   w_take;
    logic   w_out_take;

    assign w_take     = i_in_valid && r_in_ready;
    assign w_out_take = r_out_valid && i_out_ready;

    // commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.in_take  = w_take;
        o_cmd.rd_start = (r_state == ST_LOAD);
        o_cmd.rd_next  = (r_state == ST_SHOW) && w_out_take && !i_status.last;
    end

    // state and handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_take && i_status.emit_req) begin
                        r_state    <= ST_LOAD;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_LOAD: begin
                    r_state     <= ST_SHOW;
                    r_out_valid <= 1'b1;
                end
                ST_SHOW: begin
                    if (w_out_take && i_status.last) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hdl/saw_dp.sv */
`default_nettype none

module saw_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire saw_pkg::t_dp_cmd                    i_cmd,
    output saw_pkg::t_dp_status                      o_status,
    input  wire logic [saw_pkg::OP_W-1:0]            i_op,
    input  wire logic signed [saw_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic [saw_pkg::FIELD_W-1:0]         i_in_seq,
    input  wire logic [saw_pkg::FIELD_W-1:0]         i_in_ack,
    input  wire logic signed [saw_pkg::SUM_W-1:0]    i_in_check,
    input  wire logic                                i_cfg_we,
    input  wire logic [saw_pkg::TMR_W-1:0]           i_cfg_data,
    output logic                                     o_out_seq,
    output logic signed [saw_pkg::CHK_W-1:0]         o_out_check,
    output logic signed [saw_pkg::BYTE_W-1:0]        o_out_byte
);

    localparam logic [saw_pkg::IDX_W-1:0] LAST_IDX =
        saw_pkg::IDX_W'(saw_pkg::PAYLOAD_BYTES - 1);

    // packet store
    logic [saw_pkg::BYTE_W-1:0] mem [saw_pkg::PAYLOAD_BYTES];
    logic [saw_pkg::BYTE_W-1:0] r_rd_data;

    logic [saw_pkg::TMR_W-1:0]   r_timeout;
    logic                        r_seq, n_seq;
    logic                        r_await, n_await;
    logic [saw_pkg::CHK_W-1:0]   r_stored_chk, n_stored_chk;
    logic [saw_pkg::TMR_W-1:0]   r_timer, n_timer;
    logic [saw_pkg::IDX_W-1:0]   r_msg_cnt, n_msg_cnt;
    logic                        r_msg_rej, n_msg_rej;
    logic [saw_pkg::CHK_W-1:0]   r_msg_sum, n_msg_sum;
    logic [saw_pkg::IDX_W-1:0]   r_pkt_cnt, n_pkt_cnt;
    logic [saw_pkg::FIELD_W-1:0] r_pkt_ack, n_pkt_ack;
    logic [saw_pkg::SUM_W-1:0]   r_pkt_chk, n_pkt_chk;
    logic [saw_pkg::SUM_W-1:0]   r_pkt_sum, n_pkt_sum;
    logic [saw_pkg::IDX_W-1:0]   r_idx;

    logic [saw_pkg::TMR_W-1:0]   w_reload;
    logic                        w_msg_first;
    logic                        w_rej;
    logic [saw_pkg::CHK_W-1:0]   w_msg_base;
    logic [saw_pkg::CHK_W-1:0]   w_msg_new;
    logic                        w_pkt_first;
    logic [saw_pkg::SUM_W-1:0]   w_pkt_base;
    logic [saw_pkg::SUM_W-1:0]   w_pkt_new;
    logic [saw_pkg::FIELD_W-1:0] w_ack_h;
    logic [saw_pkg::SUM_W-1:0]   w_chk_h;
    logic                        w_ack_ok;
    logic                        w_mem_we;
    logic                        w_emit;
    logic [saw_pkg::IDX_W-1:0]   w_rd_addr;

    // zero timeout behaves as one tick
    assign w_reload = (r_timeout == '0) ? saw_pkg::TMR_W'(1) : r_timeout;

    // message checksum: seq bit + sum of signed bytes, 13-bit wrap
    assign w_msg_first = (r_msg_cnt == '0);
    assign w_rej       = w_msg_first ? r_await : r_msg_rej;
    assign w_msg_base  = w_msg_first ? {{(saw_pkg::CHK_W-1){1'b0}}, r_seq} : r_msg_sum;
    assign w_msg_new   = w_msg_base
                       + {{(saw_pkg::CHK_W-saw_pkg::BYTE_W){i_data_byte[saw_pkg::BYTE_W-1]}},
                          i_data_byte};

    // ack packet checksum: seq + ack + bytes, 23-bit wrap
    assign w_pkt_first = (r_pkt_cnt == '0);
    assign w_pkt_base  = w_pkt_first
        ? ({{(saw_pkg::SUM_W-saw_pkg::FIELD_W){1'b0}}, i_in_seq}
           + {{(saw_pkg::SUM_W-saw_pkg::FIELD_W){1'b0}}, i_in_ack})
        : r_pkt_sum;
    assign w_pkt_new   = w_pkt_base
                       + {{(saw_pkg::SUM_W-saw_pkg::BYTE_W){i_data_byte[saw_pkg::BYTE_W-1]}},
                          i_data_byte};
    assign w_ack_h     = w_pkt_first ? i_in_ack : r_pkt_ack;
    assign w_chk_h     = w_pkt_first ? i_in_check : r_pkt_chk;
    assign w_ack_ok    = (w_ack_h == {{(saw_pkg::FIELD_W-1){1'b0}}, r_seq})
                      && (w_pkt_new == w_chk_h) && r_await;

    // next-state logic for one accepted word
    always_comb begin
        n_seq        = r_seq;
        n_await      = r_await;
        n_stored_chk = r_stored_chk;
        n_timer      = r_timer;
        n_msg_cnt    = r_msg_cnt;
        n_msg_rej    = r_msg_rej;
        n_msg_sum    = r_msg_sum;
        n_pkt_cnt    = r_pkt_cnt;
        n_pkt_ack    = r_pkt_ack;
        n_pkt_chk    = r_pkt_chk;
        n_pkt_sum    = r_pkt_sum;
        w_mem_we     = 1'b0;
        w_emit       = 1'b0;
        case (i_op)
            saw_pkg::OP_MSG: begin
                w_mem_we  = !w_rej;
                n_msg_rej = w_rej;
                n_msg_sum = w_msg_new;
                if (r_msg_cnt == LAST_IDX) begin
                    n_msg_cnt = '0;
                    if (!w_rej) begin
                        n_stored_chk = w_msg_new;
                        n_await      = 1'b1;
                        n_timer      = w_reload;
                        w_emit       = 1'b1;
                    end
                end else begin
                    n_msg_cnt = r_msg_cnt + 1'b1;
                end
            end
            saw_pkg::OP_ACK: begin
                n_pkt_ack = w_ack_h;
                n_pkt_chk = w_chk_h;
                n_pkt_sum = w_pkt_new;
                if (r_pkt_cnt == LAST_IDX) begin
                    n_pkt_cnt = '0;
                    if (w_ack_ok) begin
                        n_timer = '0;
                        n_seq   = !r_seq;
                        n_await = 1'b0;
                    end
                end else begin
                    n_pkt_cnt = r_pkt_cnt + 1'b1;
                end
            end
            saw_pkg::OP_TICK: begin
                if (r_await && (r_timer != '0)) begin
                    if (r_timer == saw_pkg::TMR_W'(1)) begin
                        n_timer = w_reload;
                        w_emit  = 1'b1;
                    end else begin
                        n_timer = r_timer - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= saw_pkg::TIMEOUT_RESET;
            r_seq        <= 1'b0;
            r_await      <= 1'b0;
            r_stored_chk <= '0;
            r_timer      <= '0;
            r_msg_cnt    <= '0;
            r_msg_rej    <= 1'b0;
            r_msg_sum    <= '0;
            r_pkt_cnt    <= '0;
            r_pkt_ack    <= '0;
            r_pkt_chk    <= '0;
            r_pkt_sum    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cmd.in_take) begin
                r_seq        <= n_seq;
                r_await      <= n_await;
                r_stored_chk <= n_stored_chk;
                r_timer      <= n_timer;
                r_msg_cnt    <= n_msg_cnt;
                r_msg_rej    <= n_msg_rej;
                r_msg_sum    <= n_msg_sum;
                r_pkt_cnt    <= n_pkt_cnt;
                r_pkt_ack    <= n_pkt_ack;
                r_pkt_chk    <= n_pkt_chk;
                r_pkt_sum    <= n_pkt_sum;
            end
        end
    end

    // store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take && w_mem_we) begin
            mem[r_msg_cnt] <= i_data_byte;
        end
    end

    // store read port, registered
    assign w_rd_addr = i_cmd.rd_start ? '0 : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start || i_cmd.rd_next) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.rd_start || i_cmd.rd_next) begin
            r_idx <= w_rd_addr;
        end
    end

    always_comb begin
        o_status           = '0;
        o_status.emit_req  = w_emit;
        o_status.last      = (r_idx == LAST_IDX);
        o_status.awaiting  = r_await;
        o_status.timer_run = (r_timer != '0);
    end

    assign o_out_seq   = r_seq;
    assign o_out_check = r_stored_chk;
    assign o_out_byte  = r_rd_data;

endmodule

`default_nettype wire

/* hdl/stop_and_wait_arq_sender.sv */
// Channel   Dir   Modport  Word
// i_in      in    sink     op, data_byte, in_seq, in_ack, in_check
// o_out     out   source   out_seq, out_ack, out_check, out_byte, out_last
// i_cfg     in    sink     timeout_ticks write data
//
// Message bytes, ack bytes and ticks are taken one per cycle; i_in.ready stays high.
// A word that sends a packet drops i_in.ready through the store read in ST_LOAD and
// PAYLOAD_BYTES output words, one per cycle while o_out.ready is high.
// The packet store has separate write and read ports; its read is registered.
// An output stall holds the current word; reset is synchronous, active low,
// and no clearing pass is needed.
`default_nettype none

module stop_and_wait_arq_sender (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    saw_in_if.sink     i_in,
    saw_out_if.source  o_out,
    saw_cfg_if.sink    i_cfg
);

    saw_pkg::t_dp_cmd    w_cmd;
    saw_pkg::t_dp_status w_status;
    logic                w_in_ready;
    logic                w_out_valid;

    // control
    saw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath
    saw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_op        (i_in.op),
        .i_data_byte (i_in.data_byte),
        .i_in_seq    (i_in.in_seq),
        .i_in_ack    (i_in.in_ack),
        .i_in_check  (i_in.in_check),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_seq   (o_out.out_seq),
        .o_out_check (o_out.out_check),
        .o_out_byte  (o_out.out_byte)
    );

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = w_out_valid;
    assign o_out.out_ack  = 1'b0;
    assign o_out.out_last = w_status.last;
    assign i_cfg.ready    = 1'b1;

    // input and output never open together
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_ready && w_out_valid))
        else $error("input ready while packet words pending");

    // the final packet word returns the block to taking input
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && o_out.ready && w_status.last) |=> w_in_ready)
        else $error("input not reopened after last packet word");

    // timer runs exactly while an acknowledgement is pending
    a_timer_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.awaiting == w_status.timer_run)
        else $error("timer and awaiting flag disagree");

    // a packet start always leads to output words after the store read
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.in_take && w_status.emit_req) |=> ##1 w_out_valid)
        else $error("packet start did not produce output");

endmodule

`default_nettype wire
